@@ design/pmmd_pkg.sv @@
// Package for the paged memory map decoder: widths, command and status codes,
// item structs and the back-end state enum. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmmd_pkg;
	localparam int ADDR_BITS = 20;
	localparam int PAGE_BITS = 12;
	localparam int BLOCK_ID_BITS = 4;
	localparam int SLOT_BITS = ADDR_BITS - PAGE_BITS;
	localparam int NUM_SLOTS = 1 << SLOT_BITS;
	localparam int LEN_BITS = ADDR_BITS + 1;
	localparam logic [7:0] FILL_VALUE = 8'h55;

	typedef enum logic [2:0] {
		CMD_READ = 3'd0, CMD_WRITE = 3'd1, CMD_ALLOC = 3'd2, CMD_FREE = 3'd3, CMD_MAP = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_LEN = 3'd1, ST_SRC_ALIGN = 3'd2, ST_WIN_ALIGN = 3'd3,
		ST_SRC_RANGE = 3'd4, ST_WIN_RANGE = 3'd5
	} status_code_t;

	typedef struct packed {
		logic [2:0] command;
		logic [ADDR_BITS-1:0] address;
		logic [ADDR_BITS-1:0] window_address;
		logic [LEN_BITS-1:0] length;
		logic use_block_size;
		logic [LEN_BITS-1:0] block_size;
		logic [BLOCK_ID_BITS-1:0] block_id;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic mapped;
		logic [BLOCK_ID_BITS-1:0] target_block;
		logic [ADDR_BITS-1:0] block_offset;
		logic [7:0] fill_byte;
		logic [7:0] data_out;
	} out_item_t;

	typedef enum logic [1:0] {OP_ACCESS, OP_ALLOC, OP_FREE, OP_MAP} op_kind_t;

	// Classified job passed from the front to the back.
	typedef struct packed {
		op_kind_t kind;
		logic run;          // table work needed
		logic is_write;
		logic [2:0] status;
		logic [SLOT_BITS-1:0] first;
		logic [SLOT_BITS-1:0] dest;
		logic [SLOT_BITS:0] count;
		logic [ADDR_BITS-1:0] address;
		logic [ADDR_BITS-1:0] shift;
		logic [BLOCK_ID_BITS-1:0] block_id;
		logic [7:0] write_data;
	} job_t;

	typedef enum logic [2:0] {BK_IDLE, BK_ACC, BK_CLEAR, BK_RUN, BK_MREAD, BK_MWRITE} bk_state_t;
endpackage
`default_nettype wire

@@ design/pmmd_front.sv @@
// Front end: classifies items, checks alignment and range, holds a two-entry
// job queue. Depends on pmmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmmd_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire pmmd_pkg::in_item_t in_item,
	output logic job_valid,
	output pmmd_pkg::job_t job,
	input wire logic job_take
);
	import pmmd_pkg::*;

	job_t cls;
	job_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic [LEN_BITS-1:0] len;
	logic [LEN_BITS:0] src_end, win_end;
	logic lmis, smis, wmis, srng, wrng;

	always_comb begin
		len = (in_item.command == CMD_ALLOC && in_item.use_block_size) ?
			in_item.block_size : in_item.length;
		src_end = {2'b0, in_item.address} + {1'b0, len};
		win_end = {2'b0, in_item.window_address} + {1'b0, len};
		lmis = |len[PAGE_BITS-1:0];
		smis = |in_item.address[PAGE_BITS-1:0];
		wmis = |in_item.window_address[PAGE_BITS-1:0];
		// start+len-1 within mask <=> start+len <= 2^ADDR_BITS (len nonzero)
		srng = (len != '0) && (src_end > (LEN_BITS+1)'(NUM_SLOTS * (1 << PAGE_BITS)));
		wrng = (len != '0) && (win_end > (LEN_BITS+1)'(NUM_SLOTS * (1 << PAGE_BITS)));
		cls = '0;
		cls.address = in_item.address;
		cls.block_id = in_item.block_id;
		cls.write_data = in_item.write_data;
		cls.first = in_item.address[ADDR_BITS-1:PAGE_BITS];
		cls.dest = in_item.window_address[ADDR_BITS-1:PAGE_BITS];
		cls.count = len[LEN_BITS-1:PAGE_BITS];
		cls.shift = in_item.window_address - in_item.address;
		cls.status = ST_OK;
		case (in_item.command)
			CMD_READ, CMD_WRITE: begin
				cls.kind = OP_ACCESS;
				cls.is_write = in_item.command == CMD_WRITE;
			end
			CMD_ALLOC: begin
				cls.kind = OP_ALLOC;
				if (lmis) cls.status = ST_LEN;
				else if (srng) cls.status = ST_SRC_RANGE;
				cls.run = cls.status == ST_OK && len != '0;
			end
			CMD_FREE: begin
				cls.kind = OP_FREE;
				cls.run = 1'b1;
			end
			CMD_MAP: begin
				cls.kind = OP_MAP;
				if (lmis) cls.status = ST_LEN;
				else if (smis) cls.status = ST_SRC_ALIGN;
				else if (wmis) cls.status = ST_WIN_ALIGN;
				else if (srng) cls.status = ST_SRC_RANGE;
				else if (wrng) cls.status = ST_WIN_RANGE;
				cls.run = cls.status == ST_OK && len != '0;
			end
			default: cls.kind = OP_FREE; // unknown: all-zero result, no work
		endcase
	end

	logic do_push;
	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign job_valid = cnt_q != 2'd0;
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (job_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(job_take);
		end
	end
endmodule
`default_nettype wire

@@ design/pmmd_back.sv @@
// Back end: slot table memory, clearing sweep, table updates and lookups,
// one-entry result register. Depends on pmmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmmd_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire pmmd_pkg::job_t job,
	output logic job_take,
	output logic empty,
	input wire logic pop,
	output pmmd_pkg::out_item_t out_item
);
	import pmmd_pkg::*;

	localparam int SLOT_W = BLOCK_ID_BITS + ADDR_BITS;

	logic [SLOT_W-1:0] mem [NUM_SLOTS];
	logic [SLOT_W-1:0] rdata_q;
	bk_state_t st_q, st_d;
	job_t cur_q;
	logic [SLOT_BITS:0] idx_q;
	logic [SLOT_BITS:0] done_q;
	logic clr_q;
	logic ovld_q;
	out_item_t res_q;

	logic rd_en, wr_en;
	logic [SLOT_BITS-1:0] rd_addr, wr_addr;
	logic [SLOT_W-1:0] wr_data;
	logic start, slot_free, last;
	logic [BLOCK_ID_BITS-1:0] r_blk;
	logic [ADDR_BITS-1:0] r_base;
	out_item_t res_d;
	logic res_load;

	assign r_blk = rdata_q[SLOT_W-1:ADDR_BITS];
	assign r_base = rdata_q[ADDR_BITS-1:0];
	assign slot_free = !ovld_q || pop;
	assign start = st_q == BK_IDLE && !clr_q && job_valid && slot_free;
	assign job_take = start;
	assign empty = !ovld_q;
	assign out_item = res_q;
	assign last = idx_q + 1'b1 == cur_q.count;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (start) begin
				if (job.kind == OP_ACCESS) st_d = BK_ACC;
				else if (!job.run) st_d = BK_IDLE;
				else if (job.kind == OP_MAP) st_d = BK_MREAD;
				else st_d = BK_RUN;
			end
			BK_ACC: st_d = BK_IDLE;
			BK_CLEAR: if (done_q[SLOT_BITS]) st_d = BK_IDLE;
			BK_RUN: begin
				if (cur_q.kind == OP_ALLOC && (last ||
					{1'b0, cur_q.first} + idx_q + 1'b1 > (SLOT_BITS+1)'(NUM_SLOTS-1)))
					st_d = BK_IDLE;
				// free: one read-ahead stage, ends after last compare
				if (cur_q.kind == OP_FREE && done_q[SLOT_BITS]) st_d = BK_IDLE;
			end
			BK_MREAD: st_d = BK_MWRITE;
			BK_MWRITE: st_d = last ? BK_IDLE : BK_MREAD;
			default: st_d = BK_IDLE;
		endcase
	end

	// Memory control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		res_load = 1'b0;
		res_d = '0;
		case (st_q)
			BK_IDLE: if (start) begin
				res_load = 1'b1;
				res_d.status = job.status;
				rd_en = 1'b1;
				rd_addr = (job.kind == OP_ACCESS) ? job.address[ADDR_BITS-1:PAGE_BITS] :
					(job.kind == OP_MAP) ? job.first : '0;
			end
			BK_ACC: begin
				res_load = 1'b1;
				if (r_blk != '0) begin
					res_d.mapped = 1'b1;
					res_d.target_block = r_blk;
					res_d.block_offset = cur_q.address - r_base;
					if (cur_q.is_write) res_d.data_out = cur_q.write_data;
				end else if (!cur_q.is_write) begin
					res_d.fill_byte = FILL_VALUE;
				end
			end
			BK_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = idx_q[SLOT_BITS-1:0];
			end
			BK_RUN: begin
				if (cur_q.kind == OP_ALLOC) begin
					wr_en = 1'b1;
					wr_addr = cur_q.first + idx_q[SLOT_BITS-1:0];
					wr_data = {cur_q.block_id, cur_q.address};
				end else begin
					// idx_q leads done_q by one: read idx, compare done
					rd_en = 1'b1;
					rd_addr = idx_q[SLOT_BITS-1:0];
					if (idx_q != '0 && r_blk == cur_q.block_id) begin
						wr_en = 1'b1;
						wr_addr = done_q[SLOT_BITS-1:0];
					end
				end
			end
			BK_MREAD: begin
				// Fetched after the previous copy has landed, so an overlapping
				// window sees the slots already written.
				rd_en = 1'b1;
				rd_addr = cur_q.first + idx_q[SLOT_BITS-1:0];
			end
			BK_MWRITE: begin
				wr_en = 1'b1;
				wr_addr = cur_q.dest + idx_q[SLOT_BITS-1:0];
				wr_data = {r_blk, r_base + cur_q.shift};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
		if (start) cur_q <= job;
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_CLEAR;
			clr_q <= 1'b1;
			idx_q <= '0;
			done_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_CLEAR) begin
				idx_q <= idx_q + 1'b1;
				if (done_q[SLOT_BITS]) clr_q <= 1'b0;
				if (idx_q == (SLOT_BITS+1)'(NUM_SLOTS - 1)) done_q <= {1'b1, {SLOT_BITS{1'b0}}};
				else done_q <= idx_q + 1'b1;
			end else if (start) begin
				idx_q <= (job.kind == OP_FREE) ? (SLOT_BITS+1)'(1) : '0;
				done_q <= '0;
			end else if (st_q == BK_RUN || st_q == BK_MWRITE) begin
				if (cur_q.kind == OP_FREE) begin
					if (done_q == (SLOT_BITS+1)'(NUM_SLOTS-1)) done_q <= {1'b1, {SLOT_BITS{1'b0}}};
					else done_q <= idx_q;
					if (!idx_q[SLOT_BITS]) idx_q <= idx_q + 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (res_load && st_q == BK_IDLE && job.kind == OP_ACCESS) ovld_q <= ovld_q && !pop;
			else if (res_load) ovld_q <= 1'b1;
			else if (pop) ovld_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ design/paged_memory_map_decoder.sv @@
// Top level of the paged memory map decoder: front classifier and back table
// engine joined by a job queue. Depends on pmmd_pkg, pmmd_front, pmmd_back.
// Timing: an access passes through the registered slot memory read and then
// the result register; a table command loads its status into the result
// register when the back takes it, and the back then writes each slot in turn
// for allocate, reads then writes each slot for map window and sweeps every
// slot for free. The back takes no new access until the last one has left
// BK_ACC. After reset a clearing pass empties every slot before work begins.
`timescale 1ns / 1ps
`default_nettype none
module paged_memory_map_decoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire pmmd_pkg::in_item_t in_item,
	output logic empty,
	input wire logic pop,
	output pmmd_pkg::out_item_t out_item
);
	import pmmd_pkg::*;

	// The job queue sits in the front; the back pulls one job at a time and
	// only when its result register is free to take the answer.
	logic job_valid, job_take;
	job_t job;

	pmmd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.job_valid(job_valid), .job(job), .job_take(job_take)
	);

	pmmd_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .empty(empty), .pop(pop), .out_item(out_item)
	);
endmodule
`default_nettype wire
